// ----- design/assert_macros.svh -----
// Assertion helpers for the ringtone parser checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, disabled while reset is low.
`define RTPAR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define RTPAR_ASSERT_NXT_NORST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rtpar_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rtpar_pkg;

  localparam int LEDS_PER_EIGHTH = 4;
  localparam int NOTE_LIMIT      = 128;

  localparam int STRIP_NUM       = LEDS_PER_EIGHTH * 8;
  localparam int STRIP_NUM_W     = 8;
  localparam int DIV_NUM_W       = 19;
  localparam int DIV_CNT_W       = 5;
  localparam int MS_PLAIN        = 240000;
  localparam int MS_DOTTED       = 360000;

  localparam logic [DIV_NUM_W-1:0] MS_PLAIN_NUM  = DIV_NUM_W'(MS_PLAIN);
  localparam logic [DIV_NUM_W-1:0] MS_DOTTED_NUM = DIV_NUM_W'(MS_DOTTED);
  localparam logic [DIV_NUM_W-1:0] STRIP_NUMER   =
    DIV_NUM_W'(STRIP_NUM) << (DIV_NUM_W - STRIP_NUM_W);
  localparam logic [DIV_CNT_W-1:0] MS_STEPS      = DIV_CNT_W'(DIV_NUM_W);
  localparam logic [DIV_CNT_W-1:0] STRIP_STEPS   = DIV_CNT_W'(STRIP_NUM_W);
  localparam logic [8:0]           NOTE_LIMIT_W  = 9'(NOTE_LIMIT);

  localparam logic [7:0]  RST_DLEN  = 8'd4;
  localparam logic [3:0]  RST_DOCT  = 4'd6;
  localparam logic [15:0] RST_TEMPO = 16'd63;

  // ASCII codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_P_LO  = 8'h70;
  localparam logic [7:0] CH_P_UP  = 8'h50;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6F;

  typedef enum logic [3:0] {
    PH_NAME, PH_HTOP, PH_HSP, PH_HEQ, PH_HNUM, PH_SEP,
    PH_DUR, PH_SHARP, PH_OCT, PH_DOT, PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_PARSE, SQ_EOT, SQ_MUL, SQ_DMS, SQ_DMS_W,
    SQ_DST, SQ_DST_W, SQ_LOAD
  } seq_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] numer;
    logic [31:0]          denom;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  // Octave-4 pitch table, semitones from c
  function automatic logic [8:0] oct4_hz(input logic [3:0] idx);
    logic [8:0] f;
    unique case (idx)
      4'd0:    f = 9'd262;
      4'd1:    f = 9'd277;
      4'd2:    f = 9'd294;
      4'd3:    f = 9'd311;
      4'd4:    f = 9'd330;
      4'd5:    f = 9'd349;
      4'd6:    f = 9'd370;
      4'd7:    f = 9'd392;
      4'd8:    f = 9'd415;
      4'd9:    f = 9'd440;
      4'd10:   f = 9'd466;
      4'd11:   f = 9'd494;
      default: f = 9'd0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ----- design/rtpar_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rtpar_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

interface rtpar_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pitch_hz;
  logic [7:0]  strip_length;
  logic [31:0] start_ms;
  logic [31:0] length_ms;
  logic        final_note;

  modport source (output valid, output pitch_hz, output strip_length, output start_ms,
                  output length_ms, output final_note, input ready);
  modport sink   (input valid, input pitch_hz, input strip_length, input start_ms,
                  input length_ms, input final_note, output ready);
endinterface

`default_nettype wire

// ----- design/rtpar_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rtpar_div import rtpar_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_NUM_W-1:0] quot_r;
  logic [31:0]          den_r;
  logic [31:0]          rem_r;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;
  logic [31:0] rem_step;

  // one restoring step per cycle
  always_comb begin
    trial    = {rem_r, num_r[DIV_NUM_W-1]};
    ge       = (trial >= {1'b0, den_r});
    diff     = trial - {1'b0, den_r};
    rem_step = ge ? diff[31:0] : trial[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r  <= req.steps;
      num_r  <= req.numer;
      den_r  <= req.denom;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - DIV_CNT_W'(1);
      num_r  <= num_r << 1;
      rem_r  <= rem_step;
      quot_r <= {quot_r[DIV_NUM_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

// ----- design/rtpar_pitch.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rtpar_pitch import rtpar_pkg::*; (
  input  logic [7:0]  letter,
  input  logic        sharp,
  input  logic        pause,
  input  logic [3:0]  octave,
  output logic [15:0] pitch_hz
);

  logic [3:0]  idx;
  logic [3:0]  semi;
  logic        known;
  logic [8:0]  base;
  logic [19:0] scaled;

  always_comb begin
    known = 1'b1;
    unique case (letter)
      CH_C:    idx = 4'd0;
      CH_D:    idx = 4'd2;
      CH_E:    idx = 4'd4;
      CH_F:    idx = 4'd5;
      CH_G:    idx = 4'd7;
      CH_A:    idx = 4'd9;
      CH_B:    idx = 4'd11;
      default: begin
        idx   = 4'd0;
        known = 1'b0;
      end
    endcase

    // b sharp wraps to c of the same octave
    if (sharp) begin
      semi = (idx == 4'd11) ? 4'd0 : idx + 4'd1;
    end else begin
      semi = idx;
    end
    base = oct4_hz(semi);

    if (octave >= 4'd4) begin
      scaled = {11'd0, base} << (octave - 4'd4);
    end else begin
      scaled = {11'd0, base} >> (4'd4 - octave);
    end

    if (pause || !known) begin
      pitch_hz = 16'd0;
    end else if (scaled > 20'hFFFF) begin
      pitch_hz = 16'hFFFF;
    end else begin
      pitch_hz = scaled[15:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/ringtone_text_note_parser_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// RTTTL ringtone parser: takes the ringtone text one byte per transaction on in_ch
// and hands out one transaction on out_ch per finished note (pitch in Hz, strip length
// in LEDs, start time and duration in ms, and a flag on the note flushed by the end
// of the text). A byte is parsed one phase step per cycle; a byte that finishes no
// note passes from SQ_PARSE through SQ_EOT back to SQ_IDLE before the next byte is
// taken. A byte that ends a note also runs one 16x16 multiply and two passes through
// a shared serial divider (19 steps for the duration, 8 for the strip length); a
// byte that ends one note and flushes another runs that sequence twice.
// in_ch stays low on ready while a byte is at work; a finished note waits in the
// output register, and parsing of further bytes goes on until another note must
// be handed out while that register is still full.
module ringtone_text_note_parser_unit import rtpar_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  rtpar_in_if.sink           in_ch,
  rtpar_out_if.source        out_ch
);

  seq_t        seq_r, seq_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  char_r, char_nxt;
  logic        eot_r, eot_nxt;
  logic [7:0]  dlen_r, dlen_nxt;
  logic [3:0]  doct_r, doct_nxt;
  logic [15:0] tempo_r, tempo_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [7:0]  key_r, key_nxt;
  logic [7:0]  letter_r, letter_nxt;
  logic        pause_r, pause_nxt;
  logic        sharp_r, sharp_nxt;
  logic        dot_r, dot_nxt;
  logic        pend_r, pend_nxt;
  logic [3:0]  oct_r, oct_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        final_r, final_nxt;
  logic        reparse_r, reparse_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [15:0] pitch_r, pitch_nxt;
  logic [31:0] ms_r, ms_nxt;
  logic [7:0]  strip_r, strip_nxt;

  logic        out_valid_r;
  logic [15:0] out_pitch_r;
  logic [7:0]  out_strip_r;
  logic [31:0] out_start_r;
  logic [31:0] out_len_r;
  logic        out_final_r;

  logic        load_out;
  logic        clear_par;
  logic        is_dig;
  logic        note_open;
  logic [15:0] pitch_calc;
  logic [8:0]  count_inc;
  logic [7:0]  q8;
  logic [9:0]  q_dot;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [7:0] c);
    logic [19:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {16'd0, c[3:0]};
    return (v > 20'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  rtpar_pitch u_pitch (
    .letter   (letter_r),
    .sharp    (sharp_r),
    .pause    (pause_r),
    .octave   (oct_r),
    .pitch_hz (pitch_calc)
  );

  rtpar_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign is_dig    = (char_r >= CH_0) && (char_r <= CH_9);
  assign note_open = pend_r && (phase_r == PH_DUR || phase_r == PH_SHARP ||
                                phase_r == PH_OCT || phase_r == PH_DOT);
  assign count_inc = {1'b0, count_r} + 9'd1;
  assign q8        = div_rsp.quot[STRIP_NUM_W-1:0];
  assign q_dot     = ({2'd0, q8} + {1'b0, q8, 1'b0}) >> 1;

  always_comb begin
    seq_nxt     = seq_r;
    phase_nxt   = phase_r;
    char_nxt    = char_r;
    eot_nxt     = eot_r;
    dlen_nxt    = dlen_r;
    doct_nxt    = doct_r;
    tempo_nxt   = tempo_r;
    acc_nxt     = acc_r;
    key_nxt     = key_r;
    letter_nxt  = letter_r;
    pause_nxt   = pause_r;
    sharp_nxt   = sharp_r;
    dot_nxt     = dot_r;
    pend_nxt    = pend_r;
    oct_nxt     = oct_r;
    elapsed_nxt = elapsed_r;
    count_nxt   = count_r;
    final_nxt   = final_r;
    reparse_nxt = reparse_r;
    prod_nxt    = prod_r;
    pitch_nxt   = pitch_r;
    ms_nxt      = ms_r;
    strip_nxt   = strip_r;
    load_out    = 1'b0;
    clear_par   = 1'b0;
    in_ch.ready = 1'b0;
    div_req     = '0;

    unique case (seq_r)
      SQ_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          char_nxt = in_ch.text_char;
          eot_nxt  = in_ch.end_of_text;
          seq_nxt  = SQ_PARSE;
        end
      end

      SQ_PARSE: begin
        unique case (phase_r)
          PH_NAME: begin
            if (char_r == CH_COLON) phase_nxt = PH_HTOP;
            seq_nxt = SQ_EOT;
          end
          PH_HTOP: begin
            if (char_r == CH_COLON) begin
              phase_nxt = PH_SEP;
            end else if (char_r == CH_SPACE) begin
              phase_nxt = PH_HSP;
            end else begin
              key_nxt   = char_r;
              acc_nxt   = '0;
              phase_nxt = PH_HEQ;
            end
            seq_nxt = SQ_EOT;
          end
          PH_HSP: begin
            if (char_r != CH_SPACE) begin
              key_nxt   = char_r;
              acc_nxt   = '0;
              phase_nxt = PH_HEQ;
            end
            seq_nxt = SQ_EOT;
          end
          PH_HEQ: begin
            phase_nxt = PH_HNUM;
            if (char_r == CH_EQ) seq_nxt = SQ_EOT;
          end
          PH_HNUM: begin
            if (is_dig) begin
              acc_nxt = acc_digit(acc_r, char_r);
              seq_nxt = SQ_EOT;
            end else begin
              if (key_r == CH_D) begin
                dlen_nxt = (acc_r > 16'd255) ? 8'd255 : acc_r[7:0];
              end else if (key_r == CH_O) begin
                doct_nxt = (acc_r > 16'd15) ? 4'd15 : acc_r[3:0];
              end else if (key_r == CH_B) begin
                tempo_nxt = acc_r;
              end
              phase_nxt = PH_HTOP;
              if (char_r == CH_COMMA) seq_nxt = SQ_EOT;
            end
          end
          PH_SEP: begin
            if (char_r == CH_SPACE || char_r == CH_COMMA) begin
              seq_nxt = SQ_EOT;
            end else begin
              pend_nxt   = 1'b1;
              pause_nxt  = 1'b0;
              sharp_nxt  = 1'b0;
              dot_nxt    = 1'b0;
              letter_nxt = '0;
              acc_nxt    = '0;
              oct_nxt    = doct_r;
              phase_nxt  = PH_DUR;
            end
          end
          PH_DUR: begin
            if (is_dig) begin
              acc_nxt = acc_digit(acc_r, char_r);
            end else begin
              if (acc_r == 16'd0) acc_nxt = {8'd0, dlen_r};
              if (char_r == CH_P_LO || char_r == CH_P_UP) begin
                pause_nxt = 1'b1;
                phase_nxt = PH_OCT;
              end else begin
                letter_nxt = char_r;
                phase_nxt  = PH_SHARP;
              end
            end
            seq_nxt = SQ_EOT;
          end
          PH_SHARP: begin
            phase_nxt = PH_OCT;
            if (char_r == CH_HASH) begin
              sharp_nxt = 1'b1;
              seq_nxt   = SQ_EOT;
            end
          end
          PH_OCT: begin
            phase_nxt = PH_DOT;
            if (is_dig) begin
              oct_nxt = char_r[3:0];
              seq_nxt = SQ_EOT;
            end
          end
          PH_DOT: begin
            if (char_r == CH_DOT) begin
              dot_nxt     = 1'b1;
              reparse_nxt = 1'b0;
            end else begin
              reparse_nxt = 1'b1;
            end
            final_nxt = 1'b0;
            seq_nxt   = SQ_MUL;
          end
          default: seq_nxt = SQ_EOT;
        endcase
      end

      SQ_EOT: begin
        if (eot_r && note_open) begin
          if (phase_r == PH_DUR) begin
            if (acc_r == 16'd0) acc_nxt = {8'd0, dlen_r};
            letter_nxt = '0;
          end
          final_nxt   = 1'b1;
          reparse_nxt = 1'b0;
          seq_nxt     = SQ_MUL;
        end else begin
          clear_par = eot_r;
          seq_nxt   = SQ_IDLE;
        end
      end

      SQ_MUL: begin
        prod_nxt  = 32'(tempo_r) * 32'(acc_r);
        pitch_nxt = pitch_calc;
        seq_nxt   = SQ_DMS;
      end

      SQ_DMS: begin
        div_req.start = 1'b1;
        div_req.numer = dot_r ? MS_DOTTED_NUM : MS_PLAIN_NUM;
        div_req.denom = prod_r;
        div_req.steps = MS_STEPS;
        seq_nxt       = SQ_DMS_W;
      end

      SQ_DMS_W: begin
        if (div_rsp.done) begin
          ms_nxt  = (prod_r == 32'd0) ? 32'd0 : 32'(div_rsp.quot);
          seq_nxt = SQ_DST;
        end
      end

      SQ_DST: begin
        div_req.start = 1'b1;
        div_req.numer = STRIP_NUMER;
        div_req.denom = {16'd0, acc_r};
        div_req.steps = STRIP_STEPS;
        seq_nxt       = SQ_DST_W;
      end

      SQ_DST_W: begin
        if (div_rsp.done) begin
          if (acc_r == 16'd0) begin
            strip_nxt = 8'd1;
          end else if (dot_r) begin
            if (q_dot == 10'd0) strip_nxt = 8'd1;
            else if (q_dot > 10'd255) strip_nxt = 8'd255;
            else strip_nxt = q_dot[7:0];
          end else begin
            strip_nxt = (q8 == 8'd0) ? 8'd1 : q8;
          end
          seq_nxt = SQ_LOAD;
        end
      end

      SQ_LOAD: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out    = 1'b1;
          elapsed_nxt = elapsed_r + ms_r;
          count_nxt   = count_inc[7:0];
          pend_nxt    = 1'b0;
          pause_nxt   = 1'b0;
          sharp_nxt   = 1'b0;
          dot_nxt     = 1'b0;
          phase_nxt   = (count_inc >= NOTE_LIMIT_W) ? PH_DONE : PH_SEP;
          if (final_r) begin
            clear_par = 1'b1;
            seq_nxt   = SQ_IDLE;
          end else if (reparse_r) begin
            seq_nxt = SQ_PARSE;
          end else begin
            seq_nxt = SQ_EOT;
          end
        end
      end

      default: seq_nxt = SQ_IDLE;
    endcase

    if (clear_par) begin
      phase_nxt   = PH_NAME;
      dlen_nxt    = RST_DLEN;
      doct_nxt    = RST_DOCT;
      tempo_nxt   = RST_TEMPO;
      acc_nxt     = '0;
      key_nxt     = '0;
      letter_nxt  = '0;
      pause_nxt   = 1'b0;
      sharp_nxt   = 1'b0;
      dot_nxt     = 1'b0;
      pend_nxt    = 1'b0;
      oct_nxt     = '0;
      elapsed_nxt = '0;
      count_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= SQ_IDLE;
      phase_r   <= PH_NAME;
      dlen_r    <= RST_DLEN;
      doct_r    <= RST_DOCT;
      tempo_r   <= RST_TEMPO;
      acc_r     <= '0;
      key_r     <= '0;
      letter_r  <= '0;
      pause_r   <= 1'b0;
      sharp_r   <= 1'b0;
      dot_r     <= 1'b0;
      pend_r    <= 1'b0;
      oct_r     <= '0;
      elapsed_r <= '0;
      count_r   <= '0;
      final_r   <= 1'b0;
      reparse_r <= 1'b0;
      eot_r     <= 1'b0;
    end else begin
      seq_r     <= seq_nxt;
      phase_r   <= phase_nxt;
      dlen_r    <= dlen_nxt;
      doct_r    <= doct_nxt;
      tempo_r   <= tempo_nxt;
      acc_r     <= acc_nxt;
      key_r     <= key_nxt;
      letter_r  <= letter_nxt;
      pause_r   <= pause_nxt;
      sharp_r   <= sharp_nxt;
      dot_r     <= dot_nxt;
      pend_r    <= pend_nxt;
      oct_r     <= oct_nxt;
      elapsed_r <= elapsed_nxt;
      count_r   <= count_nxt;
      final_r   <= final_nxt;
      reparse_r <= reparse_nxt;
      eot_r     <= eot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r  <= char_nxt;
    prod_r  <= prod_nxt;
    pitch_r <= pitch_nxt;
    ms_r    <= ms_nxt;
    strip_r <= strip_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pitch_r <= pitch_r;
      out_strip_r <= strip_r;
      out_start_r <= elapsed_r;
      out_len_r   <= ms_r;
      out_final_r <= final_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pitch_hz     = out_pitch_r;
  assign out_ch.strip_length = out_strip_r;
  assign out_ch.start_ms     = out_start_r;
  assign out_ch.length_ms    = out_len_r;
  assign out_ch.final_note   = out_final_r;

endmodule

`default_nettype wire

// ----- design/rtpar_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rtpar_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pitch_hz,
  input logic [7:0]  out_strip_length,
  input logic        out_final_note
);

  `RTPAR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `RTPAR_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_pitch_hz) && $stable(out_strip_length), "result changed while stalled")
  `RTPAR_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready, "byte taken while previous still parsing")
  `RTPAR_ASSERT_NXT(a_final_stable, clk, rst_n, out_valid && !out_ready, $stable(out_final_note), "final flag changed while stalled")
  `RTPAR_ASSERT_NXT_NORST(a_reset_state, clk, !rst_n, in_ready && !out_valid, "not idle after reset")

endmodule

bind ringtone_text_note_parser_unit rtpar_chk u_rtpar_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_pitch_hz     (out_ch.pitch_hz),
  .out_strip_length (out_ch.strip_length),
  .out_final_note   (out_ch.final_note)
);

`default_nettype wire
